// ===== design/amhd_pkg.sv =====
// Shared types and codes for the alarm hysteresis and deadband monitor.
// Used by the register block, the evaluation core and the top level.
package amhd_pkg;

  localparam int AddrWidth = 5;
  localparam int DataWidth = 32;

  // Register indexes (byte address = 4 * index)
  localparam logic [2:0] REG_HIHI_LIMIT       = 3'd0;
  localparam logic [2:0] REG_HIGH_LIMIT       = 3'd1;
  localparam logic [2:0] REG_LOW_LIMIT        = 3'd2;
  localparam logic [2:0] REG_LOLO_LIMIT       = 3'd3;
  localparam logic [2:0] REG_HYSTERESIS       = 3'd4;
  localparam logic [2:0] REG_VALUE_DEADBAND   = 3'd5;
  localparam logic [2:0] REG_ARCHIVE_DEADBAND = 3'd6;
  localparam logic [2:0] REG_SEVERITIES       = 3'd7;

  // Alarm condition codes
  localparam logic [2:0] COND_NONE      = 3'd0;
  localparam logic [2:0] COND_UNDEFINED = 3'd1;
  localparam logic [2:0] COND_HIHI      = 3'd2;
  localparam logic [2:0] COND_LOLO      = 3'd3;
  localparam logic [2:0] COND_HIGH     = 3'd4;
  localparam logic [2:0] COND_LOW       = 3'd5;

  localparam logic [1:0] SEV_NONE = 2'd0;

  typedef struct packed {
    logic signed [31:0] sample;
    logic               undefined;
  } sample_t;

  typedef struct packed {
    logic [2:0] condition;
    logic [1:0] severity;
    logic       value_event;
    logic       archive_event;
  } result_t;

  typedef struct packed {
    logic [1:0] undefined;
    logic [1:0] low;
    logic [1:0] high;
    logic [1:0] lolo;
    logic [1:0] hihi;
  } severities_t;

  typedef struct packed {
    logic signed [31:0] hihi_limit;
    logic signed [31:0] high_limit;
    logic signed [31:0] low_limit;
    logic signed [31:0] lolo_limit;
    logic [30:0]        hysteresis;
    logic [30:0]        value_deadband;
    logic [30:0]        archive_deadband;
    severities_t        severities;
  } cfg_t;

endpackage

// ===== design/amhd_regs.sv =====
// Configuration register file behind an APB-style port.
// Depends on amhd_pkg for the register indexes and the cfg_t bundle.
module amhd_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [amhd_pkg::AddrWidth-1:0] paddr,
  input  logic [amhd_pkg::DataWidth-1:0] pwdata,
  output logic [amhd_pkg::DataWidth-1:0] prdata,
  output logic                           pready,
  output amhd_pkg::cfg_t                 cfg
);

  logic [2:0] index;
  logic       wr_en;

  assign index  = paddr[4:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      unique case (index)
        amhd_pkg::REG_HIHI_LIMIT:       cfg.hihi_limit       <= pwdata;
        amhd_pkg::REG_HIGH_LIMIT:       cfg.high_limit       <= pwdata;
        amhd_pkg::REG_LOW_LIMIT:        cfg.low_limit        <= pwdata;
        amhd_pkg::REG_LOLO_LIMIT:       cfg.lolo_limit       <= pwdata;
        amhd_pkg::REG_HYSTERESIS:       cfg.hysteresis       <= pwdata[30:0];
        amhd_pkg::REG_VALUE_DEADBAND:   cfg.value_deadband   <= pwdata[30:0];
        amhd_pkg::REG_ARCHIVE_DEADBAND: cfg.archive_deadband <= pwdata[30:0];
        amhd_pkg::REG_SEVERITIES:       cfg.severities       <= pwdata[9:0];
        default:                        cfg                  <= cfg;
      endcase
    end
  end

  always_comb begin
    unique case (index)
      amhd_pkg::REG_HIHI_LIMIT:       prdata = cfg.hihi_limit;
      amhd_pkg::REG_HIGH_LIMIT:       prdata = cfg.high_limit;
      amhd_pkg::REG_LOW_LIMIT:        prdata = cfg.low_limit;
      amhd_pkg::REG_LOLO_LIMIT:       prdata = cfg.lolo_limit;
      amhd_pkg::REG_HYSTERESIS:       prdata = {1'b0, cfg.hysteresis};
      amhd_pkg::REG_VALUE_DEADBAND:   prdata = {1'b0, cfg.value_deadband};
      amhd_pkg::REG_ARCHIVE_DEADBAND: prdata = {1'b0, cfg.archive_deadband};
      amhd_pkg::REG_SEVERITIES:       prdata = {22'd0, cfg.severities};
      default:                        prdata = '0;
    endcase
  end

endmodule

// ===== design/amhd_core.sv =====
// Alarm and deadband evaluation for one sample, plus the remembered levels.
// Depends on amhd_pkg for the sample, result and configuration types.
module amhd_core (
  input  logic                clk,
  input  logic                rst,
  input  amhd_pkg::cfg_t      cfg,
  input  amhd_pkg::sample_t   item,
  input  logic                advance,
  output amhd_pkg::result_t   result
);

  logic signed [31:0] last_alarm_level;
  logic signed [31:0] last_alarm_level_next;
  logic signed [31:0] last_monitored;
  logic signed [31:0] last_archived;

  logic signed [32:0] val_w;
  logic signed [32:0] hyst_w;
  logic signed [32:0] hihi_band;
  logic signed [32:0] high_band;
  logic signed [32:0] lolo_band;
  logic signed [32:0] low_band;
  logic signed [32:0] mon_hi;
  logic signed [32:0] mon_lo;
  logic signed [32:0] arc_hi;
  logic signed [32:0] arc_lo;

  logic hihi_hit;
  logic lolo_hit;
  logic high_hit;
  logic low_hit;

  assign val_w  = {item.sample[31], item.sample};
  assign hyst_w = {2'b00, cfg.hysteresis};

  // Release bands: limit -/+ hysteresis, one bit wider so nothing wraps
  assign hihi_band = {cfg.hihi_limit[31], cfg.hihi_limit} - hyst_w;
  assign high_band = {cfg.high_limit[31], cfg.high_limit} - hyst_w;
  assign lolo_band = {cfg.lolo_limit[31], cfg.lolo_limit} + hyst_w;
  assign low_band  = {cfg.low_limit[31], cfg.low_limit} + hyst_w;

  assign hihi_hit = (cfg.severities.hihi != amhd_pkg::SEV_NONE) &&
                    ((item.sample >= cfg.hihi_limit) ||
                     (last_alarm_level == cfg.hihi_limit && val_w >= hihi_band));
  assign lolo_hit = (cfg.severities.lolo != amhd_pkg::SEV_NONE) &&
                    ((item.sample <= cfg.lolo_limit) ||
                     (last_alarm_level == cfg.lolo_limit && val_w <= lolo_band));
  assign high_hit = (cfg.severities.high != amhd_pkg::SEV_NONE) &&
                    ((item.sample >= cfg.high_limit) ||
                     (last_alarm_level == cfg.high_limit && val_w >= high_band));
  assign low_hit  = (cfg.severities.low != amhd_pkg::SEV_NONE) &&
                    ((item.sample <= cfg.low_limit) ||
                     (last_alarm_level == cfg.low_limit && val_w <= low_band));

  // Deadband window around the last reported value
  assign mon_hi = {last_monitored[31], last_monitored} + {2'b00, cfg.value_deadband};
  assign mon_lo = {last_monitored[31], last_monitored} - {2'b00, cfg.value_deadband};
  assign arc_hi = {last_archived[31], last_archived} + {2'b00, cfg.archive_deadband};
  assign arc_lo = {last_archived[31], last_archived} - {2'b00, cfg.archive_deadband};

  always_comb begin
    result                = '0;
    last_alarm_level_next = last_alarm_level;
    if (item.undefined) begin
      if (cfg.severities.undefined != amhd_pkg::SEV_NONE) begin
        result.condition = amhd_pkg::COND_UNDEFINED;
        result.severity  = cfg.severities.undefined;
      end
    end else begin
      priority if (hihi_hit) begin
        result.condition      = amhd_pkg::COND_HIHI;
        result.severity       = cfg.severities.hihi;
        last_alarm_level_next = cfg.hihi_limit;
      end else if (lolo_hit) begin
        result.condition      = amhd_pkg::COND_LOLO;
        result.severity       = cfg.severities.lolo;
        last_alarm_level_next = cfg.lolo_limit;
      end else if (high_hit) begin
        result.condition      = amhd_pkg::COND_HIGH;
        result.severity       = cfg.severities.high;
        last_alarm_level_next = cfg.high_limit;
      end else if (low_hit) begin
        result.condition      = amhd_pkg::COND_LOW;
        result.severity       = cfg.severities.low;
        last_alarm_level_next = cfg.low_limit;
      end else begin
        // no alarm: level follows the value
        last_alarm_level_next = item.sample;
      end
    end
    result.value_event   = (val_w > mon_hi) || (val_w < mon_lo);
    result.archive_event = (val_w > arc_hi) || (val_w < arc_lo);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_alarm_level <= '0;
      last_monitored   <= '0;
      last_archived    <= '0;
    end else if (advance) begin
      last_alarm_level <= last_alarm_level_next;
      if (result.value_event) begin
        last_monitored <= item.sample;
      end
      if (result.archive_event) begin
        last_archived <= item.sample;
      end
    end
  end

endmodule

// ===== design/alarm_hysteresis_and_deadband_monitor_unit.sv =====
// Top level of the alarm hysteresis and deadband monitor.
// Depends on amhd_pkg, amhd_regs and amhd_core.
//
// Usage:
//   Sample channel: sample_valid / sample_stall / sample_item carry one
//   request (a signed Q16.16 sample plus an undefined flag). A request is
//   taken at a clock edge with sample_valid high and sample_stall low.
//   Result channel: result_valid / result_stall / result_item carry the
//   alarm condition, its severity and the value and archive event flags.
//   Path: a request lands in the input register, is evaluated in one pass
//   of compare logic and is then registered into result_item.
//   Throughput: one request per cycle unless stalled; the remembered alarm
//   level and deadband values are updated in the same cycle the result is
//   registered, so back-to-back requests see each other's effect.
//   Stall: while result_stall holds a pending result, one more request is
//   held in the input register; after that sample_stall rises.
//   Reset (rst, synchronous): clears the configuration, the remembered
//   levels and both pipeline valids. The user must write configuration
//   through the APB port only while no request is in flight; the block
//   itself does not enforce this.
module alarm_hysteresis_and_deadband_monitor_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [amhd_pkg::AddrWidth-1:0] paddr,
  input  logic [amhd_pkg::DataWidth-1:0] pwdata,
  output logic [amhd_pkg::DataWidth-1:0] prdata,
  output logic                           pready,
  input  logic                           sample_valid,
  output logic                           sample_stall,
  input  amhd_pkg::sample_t              sample_item,
  output logic                           result_valid,
  input  logic                           result_stall,
  output amhd_pkg::result_t              result_item
);

  amhd_pkg::cfg_t    cfg;
  amhd_pkg::sample_t held;
  amhd_pkg::result_t result_next;
  logic              held_valid;
  logic              advance;
  logic              take;

  amhd_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  amhd_core u_core (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .item    (held),
    .advance (advance),
    .result  (result_next)
  );

  // Move the held request forward when the result register is free
  assign advance      = held_valid && (!result_valid || !result_stall);
  assign sample_stall = held_valid && result_valid && result_stall;
  assign take         = sample_valid && !sample_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (take) begin
        held_valid <= 1'b1;
      end else if (advance) begin
        held_valid <= 1'b0;
      end
      if (advance) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      held <= sample_item;
    end
    if (advance) begin
      result_item <= result_next;
    end
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the alarm hysteresis and deadband monitor unit.
// Depends on amhd_pkg and the RTL top alarm_hysteresis_and_deadband_monitor_unit.
// Compares every result against an in-bench alarm predictor over several configurations.
module testbench;

  localparam int IdleLimit = 2000;
  localparam int BurstCycles = 300;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [amhd_pkg::AddrWidth-1:0] paddr = '0;
  logic [amhd_pkg::DataWidth-1:0] pwdata = '0;
  logic [amhd_pkg::DataWidth-1:0] prdata;
  logic pready;
  logic sample_valid = 1'b0;
  logic sample_stall;
  amhd_pkg::sample_t sample_item = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  amhd_pkg::result_t result_item;

  alarm_hysteresis_and_deadband_monitor_unit dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .sample_valid(sample_valid), .sample_stall(sample_stall), .sample_item(sample_item),
    .result_valid(result_valid), .result_stall(result_stall), .result_item(result_item)
  );

  always #5 clk = ~clk;

  // Predictor state and configuration copy
  amhd_pkg::cfg_t cfg_model = '0;
  longint alarm_level = 0;
  longint monitored_level = 0;
  longint archived_level = 0;
  logic signed [31:0] walk_value = '0;

  amhd_pkg::sample_t pending_samples[$];
  amhd_pkg::result_t expected_results[$];

  int sender_idle_pct = 0;
  int recv_stall_pct = 0;
  int burst_trigger = 0;
  int burst_seen = 0;
  int stall_left = 0;
  int idle_cycles = 0;
  int errors = 0;

  function automatic amhd_pkg::result_t predict_alarm(amhd_pkg::sample_t s);
    longint v, hh, hi, lo, ll, hys, d;
    amhd_pkg::result_t r;
    v = longint'($signed(s.sample));
    hh = longint'($signed(cfg_model.hihi_limit));
    hi = longint'($signed(cfg_model.high_limit));
    lo = longint'($signed(cfg_model.low_limit));
    ll = longint'($signed(cfg_model.lolo_limit));
    hys = longint'(cfg_model.hysteresis);
    r = '0;
    if (s.undefined) begin
      // alarm level holds on an undefined sample
      if (cfg_model.severities.undefined != amhd_pkg::SEV_NONE) begin
        r.condition = amhd_pkg::COND_UNDEFINED;
        r.severity = cfg_model.severities.undefined;
      end
    end else if (cfg_model.severities.hihi != amhd_pkg::SEV_NONE &&
                 (v >= hh || (alarm_level == hh && v >= hh - hys))) begin
      r.condition = amhd_pkg::COND_HIHI;
      r.severity = cfg_model.severities.hihi;
      alarm_level = hh;
    end else if (cfg_model.severities.lolo != amhd_pkg::SEV_NONE &&
                 (v <= ll || (alarm_level == ll && v <= ll + hys))) begin
      r.condition = amhd_pkg::COND_LOLO;
      r.severity = cfg_model.severities.lolo;
      alarm_level = ll;
    end else if (cfg_model.severities.high != amhd_pkg::SEV_NONE &&
                 (v >= hi || (alarm_level == hi && v >= hi - hys))) begin
      r.condition = amhd_pkg::COND_HIGH;
      r.severity = cfg_model.severities.high;
      alarm_level = hi;
    end else if (cfg_model.severities.low != amhd_pkg::SEV_NONE &&
                 (v <= lo || (alarm_level == lo && v <= lo + hys))) begin
      r.condition = amhd_pkg::COND_LOW;
      r.severity = cfg_model.severities.low;
      alarm_level = lo;
    end else begin
      alarm_level = v;
    end
    d = monitored_level - v;
    if (d < 0) d = -d;
    if (d > longint'(cfg_model.value_deadband)) begin
      r.value_event = 1'b1;
      monitored_level = v;
    end
    d = archived_level - v;
    if (d < 0) d = -d;
    if (d > longint'(cfg_model.archive_deadband)) begin
      r.archive_event = 1'b1;
      archived_level = v;
    end
    return r;
  endfunction

  // Sample driver: keep valid high across back-to-back requests
  always @(posedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
    end else begin
      if (sample_valid && !sample_stall) begin
        expected_results.push_back(predict_alarm(sample_item));
      end
      if (!sample_valid || !sample_stall) begin
        if (pending_samples.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
          sample_valid <= 1'b1;
          sample_item <= pending_samples.pop_front();
        end else begin
          sample_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and receiver stall
  always @(posedge clk) begin
    amhd_pkg::result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result: condition %0d severity %0d",
               result_item.condition, result_item.severity);
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (result_item.condition !== want.condition) begin
          $error("condition: expected %0d, got %0d", want.condition, result_item.condition);
          errors++;
        end
        if (result_item.severity !== want.severity) begin
          $error("severity: expected %0d, got %0d", want.severity, result_item.severity);
          errors++;
        end
        if (result_item.value_event !== want.value_event) begin
          $error("value_event: expected %0d, got %0d", want.value_event,
                 result_item.value_event);
          errors++;
        end
        if (result_item.archive_event !== want.archive_event) begin
          $error("archive_event: expected %0d, got %0d", want.archive_event,
                 result_item.archive_event);
          errors++;
        end
      end
    end
    if (rst) begin
      result_stall <= 1'b0;
    end else if (burst_trigger != burst_seen) begin
      burst_seen <= burst_trigger;
      stall_left <= BurstCycles;
      result_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      result_stall <= 1'b1;
    end else begin
      result_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (rst || psel || (sample_valid && !sample_stall) || (result_valid && !result_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      amhd_pkg::REG_HIHI_LIMIT: cfg_model.hihi_limit = value;
      amhd_pkg::REG_HIGH_LIMIT: cfg_model.high_limit = value;
      amhd_pkg::REG_LOW_LIMIT: cfg_model.low_limit = value;
      amhd_pkg::REG_LOLO_LIMIT: cfg_model.lolo_limit = value;
      amhd_pkg::REG_HYSTERESIS: cfg_model.hysteresis = value[30:0];
      amhd_pkg::REG_VALUE_DEADBAND: cfg_model.value_deadband = value[30:0];
      amhd_pkg::REG_ARCHIVE_DEADBAND: cfg_model.archive_deadband = value[30:0];
      amhd_pkg::REG_SEVERITIES: cfg_model.severities = value[9:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [31:0] hh, input logic [31:0] hi,
                            input logic [31:0] lo, input logic [31:0] ll,
                            input logic [31:0] hys, input logic [31:0] vdb,
                            input logic [31:0] adb, input logic [31:0] sev);
    write_reg(amhd_pkg::REG_HIHI_LIMIT, hh);
    write_reg(amhd_pkg::REG_HIGH_LIMIT, hi);
    write_reg(amhd_pkg::REG_LOW_LIMIT, lo);
    write_reg(amhd_pkg::REG_LOLO_LIMIT, ll);
    write_reg(amhd_pkg::REG_HYSTERESIS, hys);
    write_reg(amhd_pkg::REG_VALUE_DEADBAND, vdb);
    write_reg(amhd_pkg::REG_ARCHIVE_DEADBAND, adb);
    write_reg(amhd_pkg::REG_SEVERITIES, sev);
  endtask

  function automatic logic [31:0] fix(input int whole);
    return 32'(whole * 65536);
  endfunction

  // Ordered limits around a random center, with a random fraction each
  task automatic ordered_config();
    int center, a, b, c, d;
    center = int'($urandom_range(2000)) - 1000;
    a = int'($urandom_range(1, 50));
    b = int'($urandom_range(1, 50));
    c = int'($urandom_range(1, 50));
    d = int'($urandom_range(1, 50));
    set_config(fix(center + c + d) + $urandom_range(65535),
               fix(center + c) + $urandom_range(65535),
               fix(center - a) + $urandom_range(65535),
               fix(center - a - b) + $urandom_range(65535),
               $urandom_range(fix(10)), $urandom_range(fix(5)), $urandom_range(fix(5)),
               $urandom_range(1023));
  endtask

  task automatic push_item(input logic [31:0] v, input logic u);
    amhd_pkg::sample_t s;
    s.sample = v;
    s.undefined = u;
    pending_samples.push_back(s);
  endtask

  // Mostly values near a limit or a slow walk, so hysteresis holds get exercised
  function automatic amhd_pkg::sample_t make_sample();
    amhd_pkg::sample_t s;
    longint lim, span, off;
    int pick;
    pick = int'($urandom_range(99));
    if (pick < 40) begin
      case ($urandom_range(3))
        0: lim = longint'($signed(cfg_model.hihi_limit));
        1: lim = longint'($signed(cfg_model.high_limit));
        2: lim = longint'($signed(cfg_model.low_limit));
        default: lim = longint'($signed(cfg_model.lolo_limit));
      endcase
      span = longint'(cfg_model.hysteresis) + 65536;
      if (span > 64'd1073741824) span = 64'd1073741824;
      off = longint'($urandom_range(32'(2 * span))) - span;
      s.sample = 32'(lim + off);
    end else if (pick < 70) begin
      s.sample = walk_value + (int'($urandom_range(262144)) - 131072);
    end else if (pick < 85) begin
      s.sample = $urandom;
    end else begin
      case ($urandom_range(3))
        0: s.sample = 32'h7fff_ffff;
        1: s.sample = 32'h8000_0000;
        2: s.sample = 32'h0000_0000;
        default: s.sample = 32'hffff_ffff;
      endcase
    end
    s.undefined = ($urandom_range(9) == 0);
    walk_value = s.sample;
    return s;
  endfunction

  task automatic wait_for_drain();
    while (pending_samples.size() > 0 || sample_valid || expected_results.size() > 0)
      @(negedge clk);
  endtask

  initial begin
    int p, n;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    for (p = 0; p < 10; p++) begin
      if (p == 1) begin
        set_config(fix(100), fix(50), fix(-50), fix(-100), fix(5), fix(1), fix(10),
                   {22'd0, 2'd3, 2'd1, 2'd1, 2'd2, 2'd2});
      end else if (p >= 2) begin
        case ((p - 2) % 4)
          0: ordered_config();
          1: set_config(32'h7fff_ffff, 32'h4000_0000, 32'hc000_0000, 32'h8000_0000,
                        32'h7fff_ffff, 32'h7fff_ffff, 32'h0, 32'h3ff);
          2: set_config($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                        $urandom, $urandom);
          default: set_config(fix(4), fix(1), fix(-1), fix(-4), 32'h7fff_ffff, 32'h0,
                              32'h0, 32'h3ff);
        endcase
      end
      @(negedge clk);
      case (p % 4)
        0: begin sender_idle_pct = 0; recv_stall_pct = 0; end
        1: begin sender_idle_pct = 68; recv_stall_pct = 0; end
        2: begin sender_idle_pct = 0; recv_stall_pct = 68; end
        default: begin sender_idle_pct = 16; recv_stall_pct = 16; end
      endcase
      if (p == 0) begin
        // reset configuration: undefined reports nothing, no limit enabled
        push_item(32'h0, 1'b1);
        push_item(32'h0, 1'b0);
        push_item(32'h1, 1'b0);
        push_item(32'hffff_ffff, 1'b0);
        push_item(32'h7fff_ffff, 1'b0);
        push_item(32'h8000_0000, 1'b0);
      end else if (p == 1) begin
        push_item(fix(0), 1'b0);
        push_item(fix(60), 1'b0);
        push_item(fix(48), 1'b0);
        push_item(fix(44), 1'b0);
        push_item(fix(101), 1'b0);
        push_item(fix(96), 1'b0);
        push_item(fix(94), 1'b0);
        push_item(fix(100), 1'b0);
        push_item(fix(-100), 1'b0);
        push_item(fix(-96), 1'b0);
        push_item(fix(-94), 1'b0);
        push_item(fix(-50), 1'b0);
        push_item(fix(-46), 1'b0);
        push_item(fix(-44), 1'b0);
        push_item(32'h7fff_ffff, 1'b1);
        push_item(32'h7fff_ffff, 1'b0);
        push_item(32'h8000_0000, 1'b0);
        push_item(32'h8000_0000, 1'b1);
        push_item(32'h7fff_ffff, 1'b0);
      end else begin
        for (n = 0; n < 240; n++) pending_samples.push_back(make_sample());
      end
      // hold the result side off while requests keep coming, so the input backs up
      if (p == 4) burst_trigger++;
      wait_for_drain();
      repeat (4) @(posedge clk);
    end
    repeat (8) @(posedge clk);
    @(negedge clk);
    errors += expected_results.size();
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/amhd_pkg.sv
design/amhd_regs.sv
design/amhd_core.sv
design/alarm_hysteresis_and_deadband_monitor_unit.sv
tb/testbench.sv
